@@ src/rtoe_pkg.sv @@
// ----------------------------------------------------------------------------
// rtoe_pkg
// Shared constants and types for the retransmission timeout estimator.
// ----------------------------------------------------------------------------
package rtoe_pkg;

  // Defaults of the top-level parameters.
  localparam int TIME_WIDTH_DEF    = 32;
  localparam int VAR_SHIFT_DEF     = 2;
  localparam int SRTT_SHIFT_DEF    = 3;
  localparam int RTO_GAIN_DEF      = 4;
  localparam int FIRST_VAR_DIV_DEF = 2;
  localparam int FLOOR_MULT_DEF    = 2;

  // Port widths.
  localparam int FIELD_W    = 32;
  localparam int FACTOR_W   = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Operation codes carried in tuser.
  localparam logic OP_SAMPLE  = 1'b0;
  localparam logic OP_BACKOFF = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MIN_RTO     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RTO     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BACKOFF     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_RTO = 2'd3;

  // Register reset values.
  localparam logic [FIELD_W-1:0]  MIN_RTO_RST     = 32'd200000;
  localparam logic [FIELD_W-1:0]  MAX_RTO_RST     = 32'd60000000;
  localparam logic [FACTOR_W-1:0] BACKOFF_RST     = 16'd307;
  localparam logic [FIELD_W-1:0]  INITIAL_RTO_RST = 32'd1000000;

  // Decoded controls of one request.
  typedef struct packed {
    logic backoff;
    logic zero_sample;
  } item_ctl_t;

endpackage

@@ src/rtoe_update.sv @@
// ----------------------------------------------------------------------------
// rtoe_update
// Next-state logic: RTT smoothing, timeout clamping and timeout backoff.
// ----------------------------------------------------------------------------
module rtoe_update #(
  parameter int TIME_WIDTH = rtoe_pkg::TIME_WIDTH_DEF,
  parameter int VAR_SHIFT  = rtoe_pkg::VAR_SHIFT_DEF,
  parameter int SRTT_SHIFT = rtoe_pkg::SRTT_SHIFT_DEF,
  parameter int RTO_GAIN   = rtoe_pkg::RTO_GAIN_DEF,
  parameter int FLOOR_MULT = rtoe_pkg::FLOOR_MULT_DEF
) (
  input  rtoe_pkg::item_ctl_t               ctl,
  input  logic [TIME_WIDTH-1:0]             sample,
  input  logic [TIME_WIDTH-1:0]             sample_div,
  input  logic [TIME_WIDTH-1:0]             srtt,
  input  logic [TIME_WIDTH-1:0]             rttvar,
  input  logic [TIME_WIDTH-1:0]             rto,
  input  logic [rtoe_pkg::FIELD_W-1:0]      min_rto,
  input  logic [rtoe_pkg::FIELD_W-1:0]      max_rto,
  input  logic [rtoe_pkg::FACTOR_W-1:0]     backoff_factor,
  output logic [TIME_WIDTH-1:0]             srtt_next,
  output logic [TIME_WIDTH-1:0]             rttvar_next,
  output logic [TIME_WIDTH-1:0]             rto_next
);

  localparam int W  = TIME_WIDTH;
  localparam int XW = TIME_WIDTH + 8;
  localparam logic [W-1:0] TMAX = '1;

  function automatic logic [W-1:0] sat_x(input logic [XW-1:0] v);
    return (v > XW'(TMAX)) ? TMAX : v[W-1:0];
  endfunction

  function automatic logic [W-1:0] sat_cfg(input logic [rtoe_pkg::FIELD_W-1:0] v);
    return (v > rtoe_pkg::FIELD_W'(TMAX)) ? TMAX : W'(v);
  endfunction

  logic [W-1:0]            lo, hi;
  logic [W-1:0]            diff;
  logic [W+VAR_SHIFT:0]    var_acc;
  logic [W+SRTT_SHIFT:0]   srtt_acc;
  logic [W-1:0]            var_upd, srtt_upd;
  logic [W-1:0]            var_s, srtt_s;
  logic [W+4:0]            gain_prod;
  logic [W:0]              cand_sum;
  logic [W-1:0]            cand_sat, cand_lo;
  logic [W+7:0]            hi_prod;
  logic [23:0]             lo_prod;
  logic [W:0]              bo_sum;
  logic [W-1:0]            bo_sat;
  logic [W+6:0]            fm_prod;
  logic [W-1:0]            fm, flo, bo_lo;

  always_comb begin
    lo = sat_cfg(min_rto);
    hi = sat_cfg(max_rto);

    // Exact EWMA: ((2^k - 1) * a + b) >> k never exceeds the larger operand.
    diff     = (srtt > sample) ? (srtt - sample) : (sample - srtt);
    var_acc  = {1'b0, rttvar, {VAR_SHIFT{1'b0}}} - (W+VAR_SHIFT+1)'(rttvar)
               + (W+VAR_SHIFT+1)'(diff);
    srtt_acc = {1'b0, srtt, {SRTT_SHIFT{1'b0}}} - (W+SRTT_SHIFT+1)'(srtt)
               + (W+SRTT_SHIFT+1)'(sample);
    var_upd  = var_acc[W+VAR_SHIFT-1:VAR_SHIFT];
    srtt_upd = srtt_acc[W+SRTT_SHIFT-1:SRTT_SHIFT];

    // A zero SRTT means no sample has been taken yet.
    if (srtt == '0) begin
      srtt_s = sample;
      var_s  = sample_div;
    end else begin
      srtt_s = srtt_upd;
      var_s  = var_upd;
    end

    gain_prod = (W+5)'(var_s) * (W+5)'(RTO_GAIN);
    cand_sum  = (W+1)'(srtt_s) + (W+1)'(sat_x(XW'(gain_prod)));
    cand_sat  = sat_x(XW'(cand_sum));
    cand_lo   = (cand_sat < lo) ? lo : cand_sat;

    // Q8.8 backoff, split so that the fraction of the low byte is truncated once.
    hi_prod = (W+8)'(rto[W-1:8]) * (W+8)'(backoff_factor);
    lo_prod = 24'(rto[7:0]) * 24'(backoff_factor);
    bo_sum  = (W+1)'(sat_x(hi_prod)) + (W+1)'(lo_prod[23:8]);
    bo_sat  = sat_x(XW'(bo_sum));
    fm_prod = (W+7)'(lo) * (W+7)'(FLOOR_MULT);
    fm      = sat_x(XW'(fm_prod));
    flo     = (rto > fm) ? rto : fm;
    bo_lo   = (bo_sat < flo) ? flo : bo_sat;

    srtt_next   = srtt;
    rttvar_next = rttvar;
    rto_next    = rto;
    if (ctl.backoff) begin
      rto_next = (bo_lo > hi) ? hi : bo_lo;
    end else if (!ctl.zero_sample) begin
      srtt_next   = srtt_s;
      rttvar_next = var_s;
      rto_next    = (cand_lo > hi) ? hi : cand_lo;
    end
  end

endmodule

@@ src/rto_estimator_top.sv @@
// ----------------------------------------------------------------------------
// rto_estimator_top
// Retransmission timeout estimator with smoothed RTT, RTT variation and
// fixed-point timeout backoff.
// ----------------------------------------------------------------------------
//  Channel   Direction  Contents
//  s_*       in         tuser: operation; tdata: sample_us
//  m_*       out        tdata: rto_us, srtt_us, rttvar_us (low bits first)
//  cfg_*     in         register write: index and data, no read-back
//
//  A request passes through the input register and then the result
//  register, where the state is updated as well.
//  One request is accepted in every cycle while results are taken.
//  When the result register is full and not taken, the input register holds
//  and s_tready falls once it is full too.
//  Synchronous reset clears the pipeline, restores the register defaults,
//  zeroes SRTT and RTTVAR and loads the timeout with max(initial, min).
// ----------------------------------------------------------------------------
module rto_estimator_top #(
  parameter int TIME_WIDTH    = rtoe_pkg::TIME_WIDTH_DEF,
  parameter int VAR_SHIFT     = rtoe_pkg::VAR_SHIFT_DEF,
  parameter int SRTT_SHIFT    = rtoe_pkg::SRTT_SHIFT_DEF,
  parameter int RTO_GAIN      = rtoe_pkg::RTO_GAIN_DEF,
  parameter int FIRST_VAR_DIV = rtoe_pkg::FIRST_VAR_DIV_DEF,
  parameter int FLOOR_MULT    = rtoe_pkg::FLOOR_MULT_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [rtoe_pkg::FIELD_W-1:0]        s_tdata,   // [31:0] sample_us
  input  logic [0:0]                          s_tuser,   // [0] operation
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [31:0] rto_us, [63:32] srtt_us, [95:64] rttvar_us
  output logic [3*rtoe_pkg::FIELD_W-1:0]      m_tdata,
  input  logic                                cfg_we,
  input  logic [rtoe_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rtoe_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int W = TIME_WIDTH;
  localparam logic [W-1:0] TMAX = '1;

  // The first sample is divided by a constant through a reciprocal multiply
  // that is exact for every W-bit dividend.
  localparam int DIV_L  = $clog2(FIRST_VAR_DIV);
  localparam int DIV_S  = W + DIV_L;
  localparam int DIV_PW = DIV_S + W;
  localparam logic [DIV_S+1:0] DIV_ONE    = 1;
  localparam logic [DIV_S+1:0] DIV_M_WIDE = ((DIV_ONE << DIV_S)
                                             + (DIV_S+2)'(FIRST_VAR_DIV - 1))
                                            / (DIV_S+2)'(FIRST_VAR_DIV);
  localparam logic [W:0]       DIV_M      = DIV_M_WIDE[W:0];

  function automatic logic [W-1:0] sat_cfg(input logic [rtoe_pkg::FIELD_W-1:0] v);
    return (v > rtoe_pkg::FIELD_W'(TMAX)) ? TMAX : W'(v);
  endfunction

  function automatic logic [W-1:0] reload_of(input logic [rtoe_pkg::FIELD_W-1:0] init_v,
                                             input logic [rtoe_pkg::FIELD_W-1:0] min_v);
    logic [W-1:0] i_s;
    logic [W-1:0] m_s;
    i_s = sat_cfg(init_v);
    m_s = sat_cfg(min_v);
    return (i_s > m_s) ? i_s : m_s;
  endfunction

  // Configuration registers.
  logic [rtoe_pkg::FIELD_W-1:0]  min_rto, max_rto, initial_rto;
  logic [rtoe_pkg::FACTOR_W-1:0] backoff_factor;
  logic [rtoe_pkg::FIELD_W-1:0]  min_rto_next, initial_rto_next;

  // Estimator state.
  logic [W-1:0] srtt, rttvar, rto;
  logic [W-1:0] srtt_next, rttvar_next, rto_next;

  // Input register.
  logic                in_valid;
  rtoe_pkg::item_ctl_t in_ctl;
  logic [W-1:0]        in_sample, in_sample_div;
  logic [W-1:0]        sample_sat;
  logic [DIV_PW-1:0]   div_prod;

  logic advance;
  logic [W-1:0] max_sat;

  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !in_valid || advance;
  assign max_sat  = sat_cfg(max_rto);

  assign sample_sat = sat_cfg(s_tdata);
  assign div_prod   = DIV_PW'(sample_sat) * DIV_PW'(DIV_M);

  always_comb begin
    min_rto_next     = min_rto;
    initial_rto_next = initial_rto;
    if (cfg_we && cfg_index == rtoe_pkg::REG_MIN_RTO) begin
      min_rto_next = cfg_data;
    end
    if (cfg_we && cfg_index == rtoe_pkg::REG_INITIAL_RTO) begin
      initial_rto_next = cfg_data;
    end
  end

  rtoe_update #(
    .TIME_WIDTH (TIME_WIDTH),
    .VAR_SHIFT  (VAR_SHIFT),
    .SRTT_SHIFT (SRTT_SHIFT),
    .RTO_GAIN   (RTO_GAIN),
    .FLOOR_MULT (FLOOR_MULT)
  ) u_update (
    .ctl            (in_ctl),
    .sample         (in_sample),
    .sample_div     (in_sample_div),
    .srtt           (srtt),
    .rttvar         (rttvar),
    .rto            (rto),
    .min_rto        (min_rto),
    .max_rto        (max_rto),
    .backoff_factor (backoff_factor),
    .srtt_next      (srtt_next),
    .rttvar_next    (rttvar_next),
    .rto_next       (rto_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid       <= 1'b0;
      m_tvalid       <= 1'b0;
      min_rto        <= rtoe_pkg::MIN_RTO_RST;
      max_rto        <= rtoe_pkg::MAX_RTO_RST;
      backoff_factor <= rtoe_pkg::BACKOFF_RST;
      initial_rto    <= rtoe_pkg::INITIAL_RTO_RST;
      srtt           <= '0;
      rttvar         <= '0;
      rto            <= reload_of(rtoe_pkg::INITIAL_RTO_RST, rtoe_pkg::MIN_RTO_RST);
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (s_tvalid && s_tready) begin
        in_ctl.backoff     <= (s_tuser[0] == rtoe_pkg::OP_BACKOFF);
        in_ctl.zero_sample <= (s_tdata == '0);
        in_sample          <= sample_sat;
        in_sample_div      <= div_prod[DIV_PW-1:DIV_S];
      end
      if (advance) begin
        m_tvalid <= in_valid;
        if (in_valid) begin
          srtt    <= srtt_next;
          rttvar  <= rttvar_next;
          m_tdata <= {rtoe_pkg::FIELD_W'(rttvar_next), rtoe_pkg::FIELD_W'(srtt_next),
                      rtoe_pkg::FIELD_W'(rto_next)};
        end
      end
      // Writes only while the pipeline is empty, up to the user; timeout reloads.
      if (cfg_we) begin
        case (cfg_index)
          rtoe_pkg::REG_MIN_RTO:     min_rto        <= cfg_data;
          rtoe_pkg::REG_MAX_RTO:     max_rto        <= cfg_data;
          rtoe_pkg::REG_BACKOFF:     backoff_factor <= cfg_data[rtoe_pkg::FACTOR_W-1:0];
          rtoe_pkg::REG_INITIAL_RTO: initial_rto    <= cfg_data;
          default:                   min_rto        <= min_rto;
        endcase
        rto <= reload_of(initial_rto_next, min_rto_next);
      end else if (advance && in_valid) begin
        rto <= rto_next;
      end
    end
  end

`ifndef ASSERT_OFF
  // Once a sample has been taken, SRTT never drops back to the empty mark.
  a_srtt_sticky: assert property (@(posedge clk) disable iff (rst)
    (srtt != '0) |=> (srtt != '0))
    else $error("SRTT returned to zero after a sample");

  // A timeout or a nonzero sample leaves the timeout at or below the upper clamp.
  a_rto_capped: assert property (@(posedge clk) disable iff (rst)
    (in_valid && advance && !cfg_we && (in_ctl.backoff || !in_ctl.zero_sample))
      |=> (rto <= max_sat))
    else $error("timeout above max_rto after update");

  // A backoff never shortens the timeout unless the upper clamp bites.
  a_backoff_grows: assert property (@(posedge clk) disable iff (rst)
    (in_valid && advance && !cfg_we && in_ctl.backoff)
      |=> (rto >= $past(rto) || rto == max_sat))
    else $error("backoff reduced the timeout");

  // A request waiting in the input register is not disturbed by a stall.
  a_input_hold: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !advance) |=> (in_valid && $stable(in_sample) && $stable(in_ctl)))
    else $error("input register changed while stalled");
`endif

endmodule

@@ tb/sv/rtoe_checker.sv @@
// ----------------------------------------------------------------------------
// rtoe_checker
// Watches the request, result and register-write channels of the timeout
// estimator, keeps its own copy of the estimator state, predicts the report
// for every accepted request and compares each returned report with it.
// ----------------------------------------------------------------------------
module rtoe_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  input  logic                                s_tready,
  input  logic [rtoe_pkg::FIELD_W-1:0]        s_tdata,    // [31:0] sample_us
  input  logic [0:0]                          s_tuser,    // [0] operation
  input  logic                                m_tvalid,
  input  logic                                m_tready,
  // [31:0] rto_us, [63:32] srtt_us, [95:64] rttvar_us
  input  logic [3*rtoe_pkg::FIELD_W-1:0]      m_tdata,
  input  logic                                cfg_we,
  input  logic [rtoe_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rtoe_pkg::CFG_DATA_W-1:0]     cfg_data,
  output int                                  fail_count,
  output int                                  pending
);

  localparam bit [63:0] TIME_MAX = (64'd1 << rtoe_pkg::TIME_WIDTH_DEF) - 64'd1;

  typedef struct {
    bit [31:0] rto;
    bit [31:0] srtt;
    bit [31:0] rttvar;
  } timer_report_t;

  timer_report_t expected_reports[$];

  bit [63:0] min_timeout;
  bit [63:0] max_timeout;
  bit [63:0] backoff_q88;
  bit [63:0] initial_timeout;

  bit [63:0] smoothed_rtt;
  bit [63:0] rtt_spread;
  bit [63:0] timeout_now;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic bit [63:0] clip_time(input bit [63:0] v);
    return (v > TIME_MAX) ? TIME_MAX : v;
  endfunction

  // Weighted average: (2^sh - 1) parts of the old value and one of the new.
  function automatic bit [63:0] blend(input bit [63:0] prev, input bit [63:0] fresh,
                                      input int sh);
    return ((((64'd1 << sh) - 64'd1) * prev) + fresh) >> sh;
  endfunction

  function automatic bit [63:0] reload_timeout();
    bit [63:0] init_v;
    bit [63:0] min_v;
    init_v = clip_time(initial_timeout);
    min_v  = clip_time(min_timeout);
    return (init_v > min_v) ? init_v : min_v;
  endfunction

  task automatic absorb_sample(input bit [63:0] rtt);
    bit [63:0] gap;
    bit [63:0] cand;
    if (rtt == 64'd0) return;
    rtt = clip_time(rtt);
    if (smoothed_rtt == 64'd0) begin
      smoothed_rtt = rtt;
      rtt_spread   = rtt / rtoe_pkg::FIRST_VAR_DIV_DEF;
    end else begin
      gap          = (smoothed_rtt > rtt) ? smoothed_rtt - rtt : rtt - smoothed_rtt;
      rtt_spread   = blend(rtt_spread, gap, rtoe_pkg::VAR_SHIFT_DEF);
      smoothed_rtt = blend(smoothed_rtt, rtt, rtoe_pkg::SRTT_SHIFT_DEF);
    end
    cand = clip_time(smoothed_rtt + clip_time(rtt_spread * rtoe_pkg::RTO_GAIN_DEF));
    if (cand < clip_time(min_timeout)) cand = clip_time(min_timeout);
    // The upper clamp comes last, so it wins when min is above max.
    if (cand > clip_time(max_timeout)) cand = clip_time(max_timeout);
    timeout_now = cand;
  endtask

  task automatic apply_backoff();
    bit [63:0] prod;
    bit [63:0] floor_v;
    bit [63:0] min_mult;
    prod     = clip_time((timeout_now * backoff_q88) >> 8);
    min_mult = clip_time(clip_time(min_timeout) * rtoe_pkg::FLOOR_MULT_DEF);
    floor_v  = (timeout_now > min_mult) ? timeout_now : min_mult;
    if (prod < floor_v) prod = floor_v;
    if (prod > clip_time(max_timeout)) prod = clip_time(max_timeout);
    timeout_now = prod;
  endtask

  task automatic check_field(input string name, input bit [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    timer_report_t want;
    timer_report_t next_report;
    if (rst) begin
      min_timeout     = rtoe_pkg::MIN_RTO_RST;
      max_timeout     = rtoe_pkg::MAX_RTO_RST;
      backoff_q88     = rtoe_pkg::BACKOFF_RST;
      initial_timeout = rtoe_pkg::INITIAL_RTO_RST;
      smoothed_rtt    = 64'd0;
      rtt_spread      = 64'd0;
      timeout_now     = reload_timeout();
      expected_reports.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_reports.size() == 0) begin
          $error("report %h returned with no request outstanding", m_tdata);
          fail_count++;
        end else begin
          want = expected_reports.pop_front();
          check_field("rto_us",    want.rto,    m_tdata[31:0]);
          check_field("srtt_us",   want.srtt,   m_tdata[63:32]);
          check_field("rttvar_us", want.rttvar, m_tdata[95:64]);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          rtoe_pkg::REG_MIN_RTO:     min_timeout     = cfg_data;
          rtoe_pkg::REG_MAX_RTO:     max_timeout     = cfg_data;
          rtoe_pkg::REG_BACKOFF:     backoff_q88     = cfg_data[rtoe_pkg::FACTOR_W-1:0];
          rtoe_pkg::REG_INITIAL_RTO: initial_timeout = cfg_data;
          default: ;
        endcase
        timeout_now = reload_timeout();
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser[0] == rtoe_pkg::OP_BACKOFF) apply_backoff();
        else absorb_sample(s_tdata);
        next_report.rto    = timeout_now[31:0];
        next_report.srtt   = smoothed_rtt[31:0];
        next_report.rttvar = rtt_spread[31:0];
        expected_reports.push_back(next_report);
      end
    end
    pending = expected_reports.size();
  end

endmodule

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Drives the timeout estimator with a directed opening and then phases of
// random RTT samples and timeouts under several register settings, with
// random gaps on both channels outside one quiet phase. The checker beside
// the block predicts and compares every report; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASE_COUNT  = 8;
  localparam int PHASE_ITEMS  = 60;
  localparam int DRAIN_CYCLES = 6;

  logic                            clk;
  logic                            rst;
  logic                            s_tvalid;
  logic                            s_tready;
  logic [rtoe_pkg::FIELD_W-1:0]    s_tdata;    // [31:0] sample_us
  logic [0:0]                      s_tuser;    // [0] operation
  logic                            m_tvalid;
  logic                            m_tready;
  // [31:0] rto_us, [63:32] srtt_us, [95:64] rttvar_us
  logic [3*rtoe_pkg::FIELD_W-1:0]  m_tdata;
  logic                            cfg_we;
  logic [rtoe_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [rtoe_pkg::CFG_DATA_W-1:0] cfg_data;

  int fail_count;
  int pending;
  int cycle_count = 0;
  bit quiet = 1'b0;

  rto_estimator_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  rtoe_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) cycle_count++;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("FAILURE");
    $finish;
  end

  // Result side: stalls at random except during the quiet phase.
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      m_tready <= quiet || ($urandom_range(99) >= 29);
    end
  end

  task automatic send_request(input logic op, input logic [31:0] sample);
    while (!quiet && $urandom_range(99) < 29) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= sample;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // The upper half of the factor write carries junk, which must be dropped.
  task automatic program_regs(input logic [31:0] min_v, input logic [31:0] max_v,
                              input logic [15:0] factor, input logic [31:0] init_v);
    cfg_we    <= 1'b1;
    cfg_index <= rtoe_pkg::REG_MIN_RTO;
    cfg_data  <= min_v;
    @(negedge clk);
    cfg_index <= rtoe_pkg::REG_MAX_RTO;
    cfg_data  <= max_v;
    @(negedge clk);
    cfg_index <= rtoe_pkg::REG_BACKOFF;
    cfg_data  <= {16'($urandom()), factor};
    @(negedge clk);
    cfg_index <= rtoe_pkg::REG_INITIAL_RTO;
    cfg_data  <= init_v;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [31:0] pick_sample(input logic [31:0] base);
    case ($urandom_range(11))
      0:       return 32'd0;
      1:       return $urandom();
      2:       return 32'hFFFF_FFFF;
      3:       return 32'($urandom_range(3, 1));
      default: return base - (base >> 2) + $urandom_range(base >> 1);
    endcase
  endfunction

  initial begin
    logic [31:0] base;
    logic [31:0] min_v;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    rst       = 1'b1;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed opening under the reset settings.
    send_request(rtoe_pkg::OP_BACKOFF, 32'd0);         // timeout before any sample
    send_request(rtoe_pkg::OP_SAMPLE,  32'd0);         // zero sample is ignored
    send_request(rtoe_pkg::OP_SAMPLE,  32'd100000);    // first sample seeds both
    send_request(rtoe_pkg::OP_SAMPLE,  32'd1);         // tiny sample; the timeout stays above the floor
    send_request(rtoe_pkg::OP_SAMPLE,  32'hFFFF_FFFF); // drives it to the ceiling
    send_request(rtoe_pkg::OP_BACKOFF, 32'hFFFF_FFFF); // sample field ignored on timeout
    send_request(rtoe_pkg::OP_SAMPLE,  32'h5555_5555);
    send_request(rtoe_pkg::OP_SAMPLE,  32'hAAAA_AAAA);
    send_request(rtoe_pkg::OP_SAMPLE,  32'd150000);
    send_request(rtoe_pkg::OP_SAMPLE,  32'd0);
    repeat (8) send_request(rtoe_pkg::OP_BACKOFF, 32'd0); // backoffs held at the ceiling

    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      wait_idle();
      case (phase)
        0: program_regs(32'd0, 32'hFFFF_FFFF, 16'hFFFF, 32'd0);
        1: program_regs(32'hFFFF_FFFF, 32'd0, 16'h0000, 32'hFFFF_FFFF);
        2: program_regs(32'd1, 32'd1000, 16'd256, 32'd500);
        3: program_regs(rtoe_pkg::MIN_RTO_RST, rtoe_pkg::MAX_RTO_RST,
                        rtoe_pkg::BACKOFF_RST, rtoe_pkg::INITIAL_RTO_RST);
        4: program_regs($urandom(), $urandom(), 16'($urandom()), $urandom());
        default: begin
          min_v = $urandom_range(500000);
          program_regs(min_v, min_v + $urandom_range(100_000_000),
                       16'($urandom_range(768, 200)), $urandom_range(3_000_000));
        end
      endcase
      quiet = (phase == 5);
      base  = $urandom_range(2_000_000, 20);
      repeat (PHASE_ITEMS) begin
        if ($urandom_range(3) == 0) send_request(rtoe_pkg::OP_BACKOFF, $urandom());
        else send_request(rtoe_pkg::OP_SAMPLE, pick_sample(base));
      end
      quiet = 1'b0;
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
